### rtl/lru_stack_distance_profiler_defines.svh
// Assertion macros shared by the profiler RTL.
`ifndef LRU_STACK_DISTANCE_PROFILER_DEFINES_SVH
`define LRU_STACK_DISTANCE_PROFILER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSDP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSDP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lsdp_pkg.sv
package lsdp_pkg;

  localparam int PAGE_SLOTS = 64;
  localparam int ADDR_WIDTH = 48;

  localparam int IDX_W       = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int HIST_DEPTH  = PAGE_SLOTS + 1;
  localparam int BUCKET_W    = $clog2(HIST_DEPTH);
  localparam int FILL_W      = BUCKET_W;
  localparam int OPCODE_W    = 1;
  localparam int PAGES_W     = 7;
  localparam int DIST_W      = 7;
  localparam int CNT_W       = 40;

  typedef logic [ADDR_WIDTH-1:0] addr_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [BUCKET_W-1:0]   bucket_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam logic [OPCODE_W-1:0] OP_ACCESS = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 1'b1;

  localparam bucket_t MISS_BUCKET = bucket_t'(PAGE_SLOTS);
  localparam fill_t   FILL_FULL   = fill_t'(PAGE_SLOTS);
  localparam cnt_t    CNT_MAX     = '1;

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

  function automatic cnt_t sat_inc(input cnt_t a);
    return (a == CNT_MAX) ? CNT_MAX : a + cnt_t'(1);
  endfunction

endpackage

### rtl/lsdp_req_if.sv
interface lsdp_req_if;
  import lsdp_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  addr_t               address;
  logic [PAGES_W-1:0]  memory_pages;

  modport source (output valid, opcode, address, memory_pages, input ready);
  modport sink   (input valid, opcode, address, memory_pages, output ready);
endinterface

### rtl/lsdp_rsp_if.sv
interface lsdp_rsp_if;
  import lsdp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] stack_distance;
  logic              cold_miss;
  cnt_t              fault_count;

  modport source (output valid, stack_distance, cold_miss, fault_count, input ready);
  modport sink   (input valid, stack_distance, cold_miss, fault_count, output ready);
endinterface

### rtl/lru_stack_distance_profiler.sv
// Access: S_WALK reads one stack entry per cycle from the top until the match or the bottom,
// then S_HBUMP bumps the distance bucket and S_RESULT loads the result (empty stack: no walk).
// Query for size k: S_QSUM sums histogram buckets k through the miss bucket, one bucket per cycle.
// One item in flight; a new item is taken once the previous result sits in the output register.
// Reset (rst_ni, asynchronous, active low) empties the stack and clears the histogram at once.
`include "lru_stack_distance_profiler_defines.svh"

module lru_stack_distance_profiler (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsdp_req_if.sink    req_i,
  lsdp_rsp_if.source  rsp_o
);
  import lsdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_HBUMP,
    S_QSUM,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  fill_t               fill_q, fill_d;
  addr_t               addr_q, addr_d;
  addr_t               carry_q, carry_d;
  idx_t                rd_idx_q, rd_idx_d;
  bucket_t             bucket_q, bucket_d;
  bucket_t             qidx_q, qidx_d;
  logic                push_q, push_d;
  cnt_t                sum_q, sum_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic                miss_q, miss_d;
  logic [HIST_DEPTH-1:0] hist_vld_q, hist_vld_d;
  logic                hrd_vld_q, hrd_vld_d;
  logic                rsp_vld_q, rsp_vld_d;
  logic [DIST_W-1:0]   rsp_dist_q, rsp_dist_d;
  logic                rsp_miss_q, rsp_miss_d;
  cnt_t                rsp_cnt_q, rsp_cnt_d;

  logic    stk_we;
  idx_t    stk_waddr, stk_raddr;
  addr_t   stk_wdata, stk_rdata;
  logic    his_we;
  bucket_t his_waddr, his_raddr;
  cnt_t    his_wdata, his_rdata, his_eff;
  fill_t   next_idx;
  bucket_t kclamp;

  lsdp_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(PAGE_SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  lsdp_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (his_we),
    .waddr_i (his_waddr),
    .wdata_i (his_wdata),
    .raddr_i (his_raddr),
    .rdata_o (his_rdata)
  );

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.stack_distance = rsp_dist_q;
  assign rsp_o.cold_miss      = rsp_miss_q;
  assign rsp_o.fault_count    = rsp_cnt_q;

  // A bucket never written since reset reads as zero.
  assign his_eff  = hrd_vld_q ? his_rdata : '0;
  assign next_idx = fill_t'(rd_idx_q) + fill_t'(1);
  assign kclamp   = (req_i.memory_pages > PAGES_W'(PAGE_SLOTS)) ? MISS_BUCKET
                                                                : bucket_t'(req_i.memory_pages);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    addr_d     = addr_q;
    carry_d    = carry_q;
    rd_idx_d   = rd_idx_q;
    bucket_d   = bucket_q;
    qidx_d     = qidx_q;
    push_d     = push_q;
    sum_d      = sum_q;
    dist_d     = dist_q;
    miss_d     = miss_q;
    hist_vld_d = hist_vld_q;
    rsp_vld_d  = rsp_vld_q;
    rsp_dist_d = rsp_dist_q;
    rsp_miss_d = rsp_miss_q;
    rsp_cnt_d  = rsp_cnt_q;
    stk_we     = 1'b0;
    stk_waddr  = rd_idx_q;
    stk_wdata  = carry_q;
    stk_raddr  = '0;
    his_we     = 1'b0;
    his_waddr  = bucket_q;
    his_wdata  = sat_inc(his_eff);
    his_raddr  = MISS_BUCKET;

    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          addr_d  = req_i.address;
          carry_d = req_i.address;
          sum_d   = '0;
          if (req_i.opcode == OP_QUERY) begin
            his_raddr = kclamp;
            qidx_d    = kclamp;
            dist_d    = '0;
            miss_d    = 1'b0;
            state_d   = S_QSUM;
          end else if (fill_q == '0) begin
            his_raddr = MISS_BUCKET;
            bucket_d  = MISS_BUCKET;
            push_d    = 1'b1;
            dist_d    = DIST_W'(PAGE_SLOTS);
            miss_d    = 1'b1;
            state_d   = S_HBUMP;
          end else begin
            stk_raddr = '0;
            rd_idx_d  = '0;
            state_d   = S_WALK;
          end
        end
      end
      // Each cycle the entry read last cycle is compared and overwritten with the entry above
      // it, so the stack shifts down behind the walk until the match or the bottom.
      S_WALK: begin
        stk_we    = 1'b1;
        stk_waddr = rd_idx_q;
        stk_wdata = carry_q;
        carry_d   = stk_rdata;
        if (stk_rdata == addr_q) begin
          bucket_d  = bucket_t'(rd_idx_q);
          his_raddr = bucket_t'(rd_idx_q);
          dist_d    = DIST_W'(rd_idx_q);
          miss_d    = 1'b0;
          push_d    = 1'b0;
          state_d   = S_HBUMP;
        end else if (next_idx < fill_q) begin
          stk_raddr = next_idx[IDX_W-1:0];
          rd_idx_d  = next_idx[IDX_W-1:0];
        end else begin
          bucket_d  = MISS_BUCKET;
          his_raddr = MISS_BUCKET;
          dist_d    = DIST_W'(PAGE_SLOTS);
          miss_d    = 1'b1;
          push_d    = (fill_q < FILL_FULL);
          state_d   = S_HBUMP;
        end
      end
      S_HBUMP: begin
        his_we               = 1'b1;
        his_waddr            = bucket_q;
        his_wdata            = sat_inc(his_eff);
        hist_vld_d[bucket_q] = 1'b1;
        if (push_q) begin
          stk_we    = 1'b1;
          stk_waddr = fill_q[IDX_W-1:0];
          stk_wdata = carry_q;
          fill_d    = fill_q + fill_t'(1);
        end
        state_d = S_RESULT;
      end
      S_QSUM: begin
        sum_d = sat_add(sum_q, his_eff);
        if (qidx_q == MISS_BUCKET) begin
          state_d = S_RESULT;
        end else begin
          qidx_d    = qidx_q + bucket_t'(1);
          his_raddr = qidx_q + bucket_t'(1);
        end
      end
      S_RESULT: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d  = 1'b1;
          rsp_dist_d = dist_q;
          rsp_miss_d = miss_q;
          rsp_cnt_d  = sum_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    hrd_vld_d = hist_vld_q[his_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      hist_vld_q <= '0;
      rsp_vld_q  <= 1'b0;
      push_q     <= 1'b0;
      hrd_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      hist_vld_q <= hist_vld_d;
      rsp_vld_q  <= rsp_vld_d;
      push_q     <= push_d;
      hrd_vld_q  <= hrd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    carry_q    <= carry_d;
    rd_idx_q   <= rd_idx_d;
    bucket_q   <= bucket_d;
    qidx_q     <= qidx_d;
    sum_q      <= sum_d;
    dist_q     <= dist_d;
    miss_q     <= miss_d;
    rsp_dist_q <= rsp_dist_d;
    rsp_miss_q <= rsp_miss_d;
    rsp_cnt_q  <= rsp_cnt_d;
  end

  `LSDP_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FILL_FULL,
                   "Stack fill count exceeds the number of pages.")
  `LSDP_ASSERT_IMP(a_walk_in_range, clk_i, rst_ni, state_q == S_WALK,
                   fill_t'(rd_idx_q) < fill_q, "Stack walk reads beyond the filled entries.")
  `LSDP_ASSERT_IMP(a_miss_distance, clk_i, rst_ni, rsp_o.valid && rsp_o.cold_miss,
                   rsp_o.stack_distance == DIST_W'(PAGE_SLOTS),
                   "A miss result carries a distance other than the miss bucket.")
  `LSDP_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready,
                    !req_i.ready, "A second transaction was taken while one is in flight.")

endmodule

### rtl/lsdp_ram.sv
module lsdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
